@@ hdl/hpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpi_pkg
// Shared types, codes and helpers for the half-pel block interpolator.
// ----------------------------------------------------------------------------
package hpi_pkg;

  localparam int ROW_PIXELS_DEF = 16;   // default lane count
  localparam int MAX_PIXELS     = 16;   // bytes carried by the result beat
  localparam int SRC_BYTES      = 17;   // reference bytes per input beat
  localparam int DST_LSB        = 136;  // first destination bit in in_tdata
  localparam int IN_DATA_W      = 264;
  localparam int OUT_DATA_W     = 128;

  // interpolation modes
  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_HORZ = 2'd1;
  localparam logic [1:0] MODE_VERT = 2'd2;
  localparam logic [1:0] MODE_BILN = 2'd3;

  // register indexes
  localparam logic [1:0] REG_INTERP_MODE = 2'd0;
  localparam logic [1:0] REG_NO_ROUND    = 2'd1;
  localparam logic [1:0] REG_AVG_DEST    = 2'd2;
  localparam logic [1:0] REG_WIDTH_SEL   = 2'd3;

  // width codes
  localparam logic [1:0] WIDTH_4    = 2'd0;
  localparam logic [1:0] WIDTH_8    = 2'd1;
  localparam logic [1:0] WIDTH_16   = 2'd2;
  localparam logic [1:0] WIDTH_RSVD = 2'd3;   // runs as sixteen

  typedef struct packed {
    logic [1:0] mode;
    logic       no_round;
    logic       avg_dest;
  } lane_ctrl_t;

  // block width in pixels; reserved code counts as sixteen
  function automatic logic [4:0] block_width(input logic [1:0] sel);
    logic [4:0] w;
    unique case (sel)
      WIDTH_4: w = 5'd4;
      WIDTH_8: w = 5'd8;
      default: w = 5'd16;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/hpi_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpi_lane
// One byte lane: copy, half-pel interpolation and destination averaging.
// ----------------------------------------------------------------------------
module hpi_lane (
  input  hpi_pkg::lane_ctrl_t ctrl,
  input  logic [7:0]          a,     // current row, this pixel
  input  logic [7:0]          b,     // current row, right neighbour
  input  logic [7:0]          c,     // previous row, this pixel
  input  logic [7:0]          d,     // previous row, right neighbour
  input  logic [7:0]          dv,    // destination byte
  output logic [7:0]          res
);

  logic       rnd;
  logic [8:0] sum_h;
  logic [8:0] sum_v;
  logic [9:0] sum_b;
  logic [7:0] interp;
  logic [8:0] sum_d;

  assign rnd   = ~ctrl.no_round;
  assign sum_h = {1'b0, a} + {1'b0, b} + {8'd0, rnd};
  assign sum_v = {1'b0, c} + {1'b0, a} + {8'd0, rnd};
  assign sum_b = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d}
               + 10'd1 + {9'd0, rnd};

  always_comb begin
    unique case (ctrl.mode)
      hpi_pkg::MODE_COPY: interp = a;
      hpi_pkg::MODE_HORZ: interp = sum_h[8:1];
      hpi_pkg::MODE_VERT: interp = sum_v[8:1];
      hpi_pkg::MODE_BILN: interp = sum_b[9:2];
    endcase
  end

  assign sum_d = {1'b0, interp} + {1'b0, dv} + 9'd1;
  assign res   = ctrl.avg_dest ? sum_d[8:1] : interp;

endmodule

@@ hdl/hpi_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpi_merge
// Gathers the lane results, zeroes bytes past the block width and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module hpi_merge #(
  parameter int LANES = hpi_pkg::ROW_PIXELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [LANES-1:0][7:0]             lane_res,
  input  logic [LANES-1:0]                  lane_en,
  input  logic                              load,
  input  logic                              last,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hpi_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_low, out_high
  output logic                              out_tlast
);

  logic [hpi_pkg::MAX_PIXELS-1:0][7:0] row;
  logic                                valid_r;
  logic                                valid_nxt;
  logic [hpi_pkg::OUT_DATA_W-1:0]      data_r;
  logic                                last_r;

  for (genvar i = 0; i < hpi_pkg::MAX_PIXELS; i++) begin : g_byte
    if (i < LANES) begin : g_live
      assign row[i] = lane_en[i] ? lane_res[i] : 8'd0;
    end else begin : g_pad
      assign row[i] = 8'd0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= row;
      last_r <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

@@ hdl/half_pel_block_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_pel_block_interpolator
// The result beat is registered: it appears in the cycle after its input beat is accepted.
// Throughput: one row per cycle; the single output register is refilled in
// the same cycle it drains, so in_tready only drops while a result is held
// and out_tready is low. Priming rows give no result beat.
// Reset (rst_n low, synchronous): registers to their reset values, row store
// cleared, primed cleared, output register empty.
// ----------------------------------------------------------------------------
// Each input beat carries one reference row (17 bytes) and, when averaging,
// the destination row. ROW_PIXELS lanes work side by side, one per pixel;
// each sees its own byte, its right neighbour and the same two bytes of the
// stored previous row. The merge stage masks lanes past the block width and
// registers the packed 16-byte result.
//
// Vertical and bilinear blocks: the first row of a block only loads the row
// store and sets primed. A result beat with tlast set ends the block and
// clears primed. Copy and horizontal rows always clear it. Every accepted
// row is written to the row store, whatever the mode.
// ----------------------------------------------------------------------------
module half_pel_block_interpolator #(
  parameter int ROW_PIXELS = hpi_pkg::ROW_PIXELS_DEF   // 4 to 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [1:0]                       cfg_wdata,
  // input rows
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // src_low[63:0], src_high[127:64], src_extra[135:128],
  // dst_low[199:136], dst_high[263:200]
  input  logic [hpi_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,   // last_row
  // result rows
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_low[63:0], out_high[127:64]
  output logic [hpi_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast   // out_last
);

  // configuration registers
  logic [1:0] interp_mode_r;
  logic       no_round_r;
  logic       avg_dest_r;
  logic [1:0] width_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_mode_r <= hpi_pkg::MODE_COPY;
      no_round_r    <= 1'b0;
      avg_dest_r    <= 1'b0;
      width_sel_r   <= hpi_pkg::WIDTH_16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpi_pkg::REG_INTERP_MODE: interp_mode_r <= cfg_wdata;
        hpi_pkg::REG_NO_ROUND:    no_round_r    <= cfg_wdata[0];
        hpi_pkg::REG_AVG_DEST:    avg_dest_r    <= cfg_wdata[0];
        hpi_pkg::REG_WIDTH_SEL:   width_sel_r   <= cfg_wdata;
      endcase
    end
  end

  hpi_pkg::lane_ctrl_t ctrl;
  assign ctrl = '{mode: interp_mode_r, no_round: no_round_r, avg_dest: avg_dest_r};

  // block width, capped at the lane count
  logic [4:0] width_raw;
  logic [4:0] width_eff;
  assign width_raw = hpi_pkg::block_width(width_sel_r);
  assign width_eff = (width_raw > 5'(ROW_PIXELS)) ? 5'(ROW_PIXELS) : width_raw;

  // unpack the row beat
  logic [hpi_pkg::SRC_BYTES-1:0][7:0] cur;
  logic [ROW_PIXELS-1:0][7:0]         dst;

  for (genvar i = 0; i < hpi_pkg::SRC_BYTES; i++) begin : g_cur
    assign cur[i] = in_tdata[8*i +: 8];
  end
  for (genvar i = 0; i < ROW_PIXELS; i++) begin : g_dst
    assign dst[i] = in_tdata[hpi_pkg::DST_LSB + 8*i +: 8];
  end

  // handshake and row control
  logic accept;
  logic two_row;
  logic prime;
  logic produce;

  assign in_tready = ~out_tvalid | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign two_row   = (interp_mode_r == hpi_pkg::MODE_VERT) ||
                     (interp_mode_r == hpi_pkg::MODE_BILN);

  // row store and primed flag: only bytes 0..ROW_PIXELS are ever read
  logic [ROW_PIXELS:0][7:0] prev_row_r;
  logic                     primed_r;
  logic                     primed_nxt;

  assign prime   = two_row & ~primed_r;
  assign produce = accept & ~prime;

  always_comb begin
    primed_nxt = primed_r;
    if (accept) begin
      if (prime) begin
        primed_nxt = 1'b1;
      end else if (!two_row || in_tlast) begin
        primed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_row_r <= '0;
      primed_r   <= 1'b0;
    end else begin
      primed_r <= primed_nxt;
      if (accept) begin
        prev_row_r <= cur[ROW_PIXELS:0];
      end
    end
  end

  // lanes
  logic [ROW_PIXELS-1:0][7:0] lane_res;
  logic [ROW_PIXELS-1:0]      lane_en;

  for (genvar i = 0; i < ROW_PIXELS; i++) begin : g_lane
    assign lane_en[i] = (5'(i) < width_eff);

    hpi_lane u_lane (
      .ctrl (ctrl),
      .a    (cur[i]),
      .b    (cur[i+1]),
      .c    (prev_row_r[i]),
      .d    (prev_row_r[i+1]),
      .dv   (dst[i]),
      .res  (lane_res[i])
    );
  end

  // merge and output register
  hpi_merge #(
    .LANES (ROW_PIXELS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_res   (lane_res),
    .lane_en    (lane_en),
    .load       (produce),
    .last       (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
